// File: rtl/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// ibhq_pkg
// Shared types, codes and defaults for the indexed binary heap queue.
// ----------------------------------------------------------------------------
package ibhq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int TAG_W         = 6;
    localparam int TAG_COUNT     = 64;
    localparam int IN_W          = 40;
    localparam int OUT_W         = 48;
    localparam int COUNT_OUT_W   = 7;

    localparam logic [1:0] MODE_INSERT     = 2'd0;
    localparam logic [1:0] MODE_REMOVE_TOP = 2'd1;
    localparam logic [1:0] MODE_REMOVE     = 2'd2;
    localparam logic [1:0] MODE_CHANGE     = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_TAG   = 2'd3;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ERR_FULL,
        ACT_ERR_EMPTY,
        ACT_ERR_TAG,
        ACT_INS,
        ACT_RM_TOP,
        ACT_RM_TAG,
        ACT_CHG,
        ACT_RMTAG_GET,
        ACT_LAST_DONE,
        ACT_LAST_MOVE,
        ACT_UP_RD,
        ACT_UP_MOVE,
        ACT_DN_RD_L,
        ACT_DN_LEFT,
        ACT_DN_RIGHT,
        ACT_DN_MOVE,
        ACT_FIN,
        ACT_TOP_RD,
        ACT_TOP_CAP,
        ACT_OUT
    } act_t;

    typedef struct packed {
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       live;
        logic       pos_ok;
        logic       p_root;
        logic       p_is_last;
        logic       first;
        logic       up_better;
        logic       l_over;
        logic       r_exists;
        logic       dn_better;
        logic       out_free;
    } sts_t;

endpackage

// File: rtl/ibhq_ram.sv
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ibhq_ctrl.sv
// ----------------------------------------------------------------------------
// ibhq_ctrl
// Sequencer: decodes the operation, then steps the sift loop one heap
// level at a time and issues datapath actions.
// ----------------------------------------------------------------------------
module ibhq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ibhq_pkg::sts_t   sts,
    output ibhq_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RMTAG, S_LAST, S_UP, S_UPCMP, S_DN, S_DNL, S_DNR,
        S_DNCMP, S_FIN, S_TOP, S_TOPW, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd.act    = ibhq_pkg::ACT_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.act    = ibhq_pkg::ACT_LOAD;
                    ready_next = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.mode == ibhq_pkg::MODE_INSERT) begin
                    if (sts.full) begin
                        cmd.act    = ibhq_pkg::ACT_ERR_FULL;
                        state_next = S_TOP;
                    end else if (sts.live) begin
                        cmd.act    = ibhq_pkg::ACT_ERR_TAG;
                        state_next = S_TOP;
                    end else begin
                        cmd.act    = ibhq_pkg::ACT_INS;
                        state_next = S_UP;
                    end
                end else if (sts.empty) begin
                    cmd.act    = ibhq_pkg::ACT_ERR_EMPTY;
                    state_next = S_TOP;
                end else if (sts.mode == ibhq_pkg::MODE_REMOVE_TOP) begin
                    cmd.act    = ibhq_pkg::ACT_RM_TOP;
                    state_next = S_RMTAG;
                end else if (!sts.pos_ok) begin
                    cmd.act    = ibhq_pkg::ACT_ERR_TAG;
                    state_next = S_TOP;
                end else if (sts.mode == ibhq_pkg::MODE_REMOVE) begin
                    cmd.act    = ibhq_pkg::ACT_RM_TAG;
                    state_next = S_LAST;
                end else begin
                    cmd.act    = ibhq_pkg::ACT_CHG;
                    state_next = S_UP;
                end
            end
            S_RMTAG: begin
                cmd.act    = ibhq_pkg::ACT_RMTAG_GET;
                state_next = S_LAST;
            end
            S_LAST: begin
                if (sts.p_is_last) begin
                    cmd.act    = ibhq_pkg::ACT_LAST_DONE;
                    state_next = S_TOP;
                end else begin
                    cmd.act    = ibhq_pkg::ACT_LAST_MOVE;
                    state_next = S_UP;
                end
            end
            S_UP: begin
                if (sts.p_root) begin
                    state_next = sts.first ? S_DN : S_FIN;
                end else begin
                    cmd.act    = ibhq_pkg::ACT_UP_RD;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (sts.up_better) begin
                    cmd.act    = ibhq_pkg::ACT_UP_MOVE;
                    state_next = S_UP;
                end else begin
                    state_next = sts.first ? S_DN : S_FIN;
                end
            end
            S_DN: begin
                if (sts.l_over) begin
                    state_next = S_FIN;
                end else begin
                    cmd.act    = ibhq_pkg::ACT_DN_RD_L;
                    state_next = S_DNL;
                end
            end
            S_DNL: begin
                cmd.act    = ibhq_pkg::ACT_DN_LEFT;
                state_next = sts.r_exists ? S_DNR : S_DNCMP;
            end
            S_DNR: begin
                cmd.act    = ibhq_pkg::ACT_DN_RIGHT;
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                if (sts.dn_better) begin
                    cmd.act    = ibhq_pkg::ACT_DN_MOVE;
                    state_next = S_DN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.act    = ibhq_pkg::ACT_FIN;
                state_next = S_TOP;
            end
            S_TOP: begin
                cmd.act    = ibhq_pkg::ACT_TOP_RD;
                state_next = S_TOPW;
            end
            S_TOPW: begin
                cmd.act    = ibhq_pkg::ACT_TOP_CAP;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.act    = ibhq_pkg::ACT_OUT;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// File: rtl/ibhq_dp.sv
// ----------------------------------------------------------------------------
// ibhq_dp
// Datapath: heap and tag-position memories, the moving entry, slot index,
// entry count, key compare and the result register.
// ----------------------------------------------------------------------------
module ibhq_dp #(
    parameter int CAPACITY  = ibhq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic [ibhq_pkg::IN_W-1:0]   s_tdata,
    input  ibhq_pkg::cmd_t              cmd,
    output ibhq_pkg::sts_t              sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ibhq_pkg::OUT_W-1:0]  m_tdata
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int TW = ibhq_pkg::TAG_W;
    localparam int EW = KEY_WIDTH + TW;

    // input fields
    logic [KEY_WIDTH+31:0] key_ext;
    logic [KEY_WIDTH-1:0]  s_key;
    logic [TW-1:0]         s_tag;

    assign key_ext = {{KEY_WIDTH{1'b0}}, s_tdata[33:2]};
    assign s_key   = key_ext[KEY_WIDTH-1:0];
    assign s_tag   = s_tdata[39:34];

    logic                 sf_reg;
    logic [1:0]           mode_reg;
    logic [KEY_WIDTH-1:0] key_in_reg;
    logic [TW-1:0]        tag_in_reg;
    logic [KEY_WIDTH-1:0] cur_key_reg;
    logic [TW-1:0]        cur_tag_reg;
    logic [PW-1:0]        p_reg;
    logic [PW-1:0]        cnt_reg;
    logic                 first_reg;
    logic [1:0]           status_reg;
    logic [KEY_WIDTH-1:0] ch_key_reg;
    logic [TW-1:0]        ch_tag_reg;
    logic [PW:0]          ch_idx_reg;
    logic [ibhq_pkg::TAG_COUNT-1:0] valid_reg;
    logic [KEY_WIDTH-1:0] top_key_reg;
    logic [TW-1:0]        top_tag_reg;
    logic                 m_tvalid_reg;
    logic [ibhq_pkg::OUT_W-1:0] m_tdata_reg;

    // memories
    logic          h_we;
    logic [AW-1:0] h_waddr, h_raddr;
    logic [EW-1:0] h_wdata, h_rdata;
    logic          t_we;
    logic [TW-1:0] t_waddr, t_raddr;
    logic [PW-1:0] t_wdata, t_rdata;

    ibhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    ibhq_ram #(.WIDTH(PW), .DEPTH(ibhq_pkg::TAG_COUNT)) u_tpos (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    logic [KEY_WIDTH-1:0] r_key;
    logic [TW-1:0]        r_tag;
    logic [PW-1:0]        parent, p_m1, cnt_m1, parent_m1;
    logic [PW:0]          l_idx, r_idx;

    assign r_key     = h_rdata[KEY_WIDTH-1:0];
    assign r_tag     = h_rdata[EW-1:KEY_WIDTH];
    assign parent    = p_reg >> 1;
    assign p_m1      = p_reg - PW'(1);
    assign cnt_m1    = cnt_reg - PW'(1);
    assign parent_m1 = parent - PW'(1);
    assign l_idx     = {p_reg, 1'b0};
    assign r_idx     = l_idx + (PW+1)'(1);

    function automatic logic better(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 sf);
        better = sf ? (a < b) : (a > b);
    endfunction

    // status toward the sequencer
    always_comb begin
        sts.mode      = mode_reg;
        sts.full      = (cnt_reg == PW'(CAPACITY));
        sts.empty     = (cnt_reg == '0);
        sts.live      = valid_reg[tag_in_reg];
        sts.pos_ok    = valid_reg[tag_in_reg] && (t_rdata != '0) && (t_rdata <= cnt_reg);
        sts.p_root    = (p_reg == PW'(1));
        sts.p_is_last = (p_reg == cnt_reg);
        sts.first     = first_reg;
        sts.up_better = better(cur_key_reg, r_key, sf_reg);
        sts.l_over    = (l_idx > {1'b0, cnt_reg});
        sts.r_exists  = (r_idx <= {1'b0, cnt_reg});
        sts.dn_better = better(ch_key_reg, cur_key_reg, sf_reg);
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    // memory ports
    always_comb begin
        h_we    = 1'b0;
        h_waddr = p_m1[AW-1:0];
        h_wdata = {cur_tag_reg, cur_key_reg};
        h_raddr = '0;
        t_we    = 1'b0;
        t_waddr = cur_tag_reg;
        t_wdata = p_reg;
        t_raddr = s_tag;
        case (cmd.act)
            ibhq_pkg::ACT_RMTAG_GET,
            ibhq_pkg::ACT_RM_TAG:  h_raddr = cnt_m1[AW-1:0];
            ibhq_pkg::ACT_UP_RD:   h_raddr = parent_m1[AW-1:0];
            ibhq_pkg::ACT_DN_RD_L: h_raddr = AW'(l_idx - (PW+1)'(1));
            ibhq_pkg::ACT_DN_LEFT: h_raddr = l_idx[AW-1:0];
            ibhq_pkg::ACT_UP_MOVE: begin
                h_we    = 1'b1;
                h_wdata = h_rdata;
                t_we    = 1'b1;
                t_waddr = r_tag;
            end
            ibhq_pkg::ACT_DN_MOVE: begin
                h_we    = 1'b1;
                h_wdata = {ch_tag_reg, ch_key_reg};
                t_we    = 1'b1;
                t_waddr = ch_tag_reg;
            end
            ibhq_pkg::ACT_FIN: begin
                h_we = 1'b1;
                t_we = 1'b1;
            end
            default: ;
        endcase
    end

    logic [KEY_WIDTH+31:0]            top_ext;
    logic [PW+ibhq_pkg::COUNT_OUT_W-1:0] cnt_ext;

    assign top_ext = {32'd0, top_key_reg};
    assign cnt_ext = {{ibhq_pkg::COUNT_OUT_W{1'b0}}, cnt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sf_reg       <= 1'b0;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sf_reg <= cfg_wr_data;
            end
            if (cmd.act == ibhq_pkg::ACT_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (cmd.act)
                ibhq_pkg::ACT_INS:       cnt_reg <= cnt_reg + PW'(1);
                ibhq_pkg::ACT_LAST_DONE,
                ibhq_pkg::ACT_LAST_MOVE: cnt_reg <= cnt_m1;
                ibhq_pkg::ACT_RMTAG_GET: valid_reg[r_tag] <= 1'b0;
                ibhq_pkg::ACT_RM_TAG:    valid_reg[tag_in_reg] <= 1'b0;
                ibhq_pkg::ACT_UP_MOVE:   valid_reg[r_tag] <= 1'b1;
                ibhq_pkg::ACT_DN_MOVE:   valid_reg[ch_tag_reg] <= 1'b1;
                ibhq_pkg::ACT_FIN:       valid_reg[cur_tag_reg] <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.act)
            ibhq_pkg::ACT_LOAD: begin
                mode_reg   <= s_tdata[1:0];
                key_in_reg <= s_key;
                tag_in_reg <= s_tag;
                status_reg <= ibhq_pkg::STATUS_OK;
            end
            ibhq_pkg::ACT_ERR_FULL:  status_reg <= ibhq_pkg::STATUS_FULL;
            ibhq_pkg::ACT_ERR_EMPTY: status_reg <= ibhq_pkg::STATUS_EMPTY;
            ibhq_pkg::ACT_ERR_TAG:   status_reg <= ibhq_pkg::STATUS_TAG;
            ibhq_pkg::ACT_INS: begin
                cur_key_reg <= key_in_reg;
                cur_tag_reg <= tag_in_reg;
                p_reg       <= cnt_reg + PW'(1);
                first_reg   <= 1'b0;
            end
            ibhq_pkg::ACT_RM_TOP: p_reg <= PW'(1);
            ibhq_pkg::ACT_RM_TAG: p_reg <= t_rdata;
            ibhq_pkg::ACT_CHG: begin
                cur_key_reg <= key_in_reg;
                cur_tag_reg <= tag_in_reg;
                p_reg       <= t_rdata;
                first_reg   <= 1'b1;
            end
            ibhq_pkg::ACT_LAST_MOVE: begin
                cur_key_reg <= r_key;
                cur_tag_reg <= r_tag;
                first_reg   <= 1'b1;
            end
            ibhq_pkg::ACT_UP_MOVE: begin
                p_reg     <= parent;
                first_reg <= 1'b0;
            end
            ibhq_pkg::ACT_DN_LEFT: begin
                ch_key_reg <= r_key;
                ch_tag_reg <= r_tag;
                ch_idx_reg <= l_idx;
            end
            ibhq_pkg::ACT_DN_RIGHT: begin
                // left wins ties
                if (better(r_key, ch_key_reg, sf_reg)) begin
                    ch_key_reg <= r_key;
                    ch_tag_reg <= r_tag;
                    ch_idx_reg <= r_idx;
                end
            end
            ibhq_pkg::ACT_DN_MOVE: p_reg <= ch_idx_reg[PW-1:0];
            ibhq_pkg::ACT_TOP_CAP: begin
                top_key_reg <= (cnt_reg != '0) ? r_key : '0;
                top_tag_reg <= (cnt_reg != '0) ? r_tag : '0;
            end
            ibhq_pkg::ACT_OUT: begin
                m_tdata_reg <= {1'b0, cnt_ext[ibhq_pkg::COUNT_OUT_W-1:0], top_tag_reg,
                                top_ext[31:0], status_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/indexed_binary_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue
// Indexed binary max/min heap priority queue with tag lookup.
// ----------------------------------------------------------------------------
// Each transaction runs to completion before the next is taken: insert, remove
// top, remove by tag or change a tag's key, each followed by a sift unless it
// ends in an error status or removes the entry in the last slot. Sifting moves
// one heap level at a time: a parent read per level moved up, or reads of the
// children per level moved down, as the heap memory has a single read port.
// A finished result waits in the output register while the next item is taken.
// Write configuration (smallest_first) only while idle.
module indexed_binary_heap_queue #(
    parameter int CAPACITY  = ibhq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,   // smallest_first
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ibhq_pkg::IN_W-1:0]  s_tdata,       // mode[1:0], key[33:2], tag[39:34]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ibhq_pkg::OUT_W-1:0] m_tdata        // status[1:0], top_key[33:2],
                                                      // top_tag[39:34], entry_count[46:40]
);

    ibhq_pkg::cmd_t cmd;
    ibhq_pkg::sts_t sts;

    ibhq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    ibhq_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tdata(s_tdata), .cmd(cmd), .sts(sts),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
